@@ rtl/jtl_pkg.sv @@
// Shared types, token codes, character constants and literal tables for the JSON lexer.
`default_nettype none

package jtl_pkg;

    localparam logic [3:0] TT_STRING   = 4'd0;
    localparam logic [3:0] TT_NUMBER   = 4'd1;
    localparam logic [3:0] TT_BOOLEAN  = 4'd2;
    localparam logic [3:0] TT_NULL     = 4'd3;
    localparam logic [3:0] TT_LBRACKET = 4'd4;
    localparam logic [3:0] TT_RBRACKET = 4'd5;
    localparam logic [3:0] TT_LBRACE   = 4'd6;
    localparam logic [3:0] TT_RBRACE   = 4'd7;
    localparam logic [3:0] TT_COLON    = 4'd8;
    localparam logic [3:0] TT_COMMA    = 4'd9;

    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    typedef struct packed {
        logic [3:0] token_type;
        logic [7:0] value_byte;
        logic       has_value_byte;
        logic       token_complete;
        logic       error_flag;
        logic       last_of_step;
    } t_result;

    // Length of each literal; unknown kind has length zero so it never matches.
    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        unique case (kind)
            LIT_TRUE:  len = 3'd4;
            LIT_FALSE: len = 3'd5;
            LIT_NULL:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (kind)
            LIT_TRUE: begin
                unique case (pos)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                unique case (pos)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            LIT_NULL: begin
                unique case (pos)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/jtl_if.sv @@
// Valid/ready channel interfaces for the lexer byte input and token output.
`default_nettype none

interface jtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jtl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_type;
    logic [7:0] value_byte;
    logic       has_value_byte;
    logic       token_complete;
    logic       error_flag;
    logic       last_of_step;

    modport source (output valid, output token_type, output value_byte,
                    output has_value_byte, output token_complete, output error_flag,
                    output last_of_step, input ready);
    modport sink (input valid, input token_type, input value_byte,
                  input has_value_byte, input token_complete, input error_flag,
                  input last_of_step, output ready);
endinterface

`default_nettype wire

@@ rtl/jtl_core.sv @@
// Input register, lexer state and per-byte token decision logic.
`default_nettype none

module jtl_core
    import jtl_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    jtl_in_if.sink       i_in,
    input  wire          i_room,
    output logic [1:0]   o_push,
    output t_result      o_res0,
    output t_result      o_res1
);

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_LITERAL = 3'd3,
        MODE_FAILED  = 3'd4
    } t_mode;

    typedef struct packed {
        logic       emit;
        logic       lit;
        logic [1:0] kind;
        t_mode      mode;
        t_result    res;
    } t_fresh;

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_eoi;
    t_mode      r_mode;
    logic [1:0] r_kind;
    logic [2:0] r_pos;

    t_mode      n_mode;
    logic [1:0] n_kind;
    logic [2:0] n_pos;
    logic       take;
    logic [1:0] cnt;
    t_result    res0;
    t_result    res1;
    t_fresh     fr;
    logic [2:0] pos_inc;

    function automatic t_result err_res();
        t_result r;
        r = '0;
        r.error_flag = 1'b1;
        return r;
    endfunction

    function automatic t_result tok(input logic [3:0] tt, input logic [7:0] v,
                                    input logic hv, input logic comp);
        t_result r;
        r = '0;
        r.token_type     = tt;
        r.value_byte     = v;
        r.has_value_byte = hv;
        r.token_complete = comp;
        return r;
    endfunction

    // Handling of a byte seen between tokens.
    function automatic t_fresh fresh(input logic [7:0] c);
        t_fresh f;
        f = '0;
        f.mode = MODE_IDLE;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            f.emit = 1'b0;
        end else if (c == CH_QUOTE) begin
            f.mode = MODE_STRING;
        end else if (c == CH_LBRACKET) begin
            f.emit = 1'b1;
            f.res  = tok(TT_LBRACKET, c, 1'b1, 1'b1);
        end else if (c == CH_RBRACKET) begin
            f.emit = 1'b1;
            f.res  = tok(TT_RBRACKET, c, 1'b1, 1'b1);
        end else if (c == CH_LBRACE) begin
            f.emit = 1'b1;
            f.res  = tok(TT_LBRACE, c, 1'b1, 1'b1);
        end else if (c == CH_RBRACE) begin
            f.emit = 1'b1;
            f.res  = tok(TT_RBRACE, c, 1'b1, 1'b1);
        end else if (c == CH_COLON) begin
            f.emit = 1'b1;
            f.res  = tok(TT_COLON, c, 1'b1, 1'b1);
        end else if (c == CH_COMMA) begin
            f.emit = 1'b1;
            f.res  = tok(TT_COMMA, c, 1'b1, 1'b1);
        end else if (c == CH_T || c == CH_F || c == CH_N) begin
            f.emit = 1'b1;
            f.lit  = 1'b1;
            f.mode = MODE_LITERAL;
            f.kind = (c == CH_T) ? LIT_TRUE : ((c == CH_F) ? LIT_FALSE : LIT_NULL);
            f.res  = tok((c == CH_N) ? TT_NULL : TT_BOOLEAN, c, 1'b1, 1'b0);
        end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS) begin
            f.emit = 1'b1;
            f.mode = MODE_NUMBER;
            f.res  = tok(TT_NUMBER, c, 1'b1, 1'b0);
        end else begin
            f.emit = 1'b1;
            f.mode = MODE_FAILED;
            f.res  = err_res();
        end
        return f;
    endfunction

    assign take       = r_vld && i_room;
    assign i_in.ready = !r_vld || take;
    assign fr         = fresh(r_byte);
    assign pos_inc    = r_pos + 3'd1;

    always_comb begin
        n_mode = r_mode;
        n_kind = r_kind;
        n_pos  = r_pos;
        cnt    = 2'd0;
        res0   = '0;
        res1   = '0;
        if (r_eoi) begin
            unique case (r_mode)
                MODE_NUMBER: begin
                    cnt    = 2'd1;
                    res0   = tok(TT_NUMBER, 8'h00, 1'b0, 1'b1);
                    n_mode = MODE_IDLE;
                end
                MODE_STRING, MODE_LITERAL: begin
                    cnt    = 2'd1;
                    res0   = err_res();
                    n_mode = MODE_FAILED;
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    cnt    = {1'b0, fr.emit};
                    res0   = fr.res;
                    n_mode = fr.mode;
                    if (fr.lit) begin
                        n_kind = fr.kind;
                        n_pos  = 3'd1;
                    end
                end
                MODE_STRING: begin
                    cnt = 2'd1;
                    if (r_byte == CH_QUOTE) begin
                        res0   = tok(TT_STRING, 8'h00, 1'b0, 1'b1);
                        n_mode = MODE_IDLE;
                    end else begin
                        res0 = tok(TT_STRING, r_byte, 1'b1, 1'b0);
                    end
                end
                MODE_NUMBER: begin
                    res0 = '0;
                    if (r_byte >= CH_ZERO && r_byte <= CH_NINE) begin
                        cnt  = 2'd1;
                        res0 = tok(TT_NUMBER, r_byte, 1'b1, 1'b0);
                    end else begin
                        cnt    = fr.emit ? 2'd2 : 2'd1;
                        res0   = tok(TT_NUMBER, 8'h00, 1'b0, 1'b1);
                        res1   = fr.res;
                        n_mode = fr.mode;
                        if (fr.lit) begin
                            n_kind = fr.kind;
                            n_pos  = 3'd1;
                        end
                    end
                end
                MODE_LITERAL: begin
                    cnt = 2'd1;
                    if (r_pos >= lit_len(r_kind) || lit_char(r_kind, r_pos) != r_byte) begin
                        res0   = err_res();
                        n_mode = MODE_FAILED;
                    end else if (pos_inc == lit_len(r_kind)) begin
                        res0   = tok((r_kind == LIT_NULL) ? TT_NULL : TT_BOOLEAN,
                                     r_byte, 1'b1, 1'b1);
                        n_mode = MODE_IDLE;
                        n_pos  = 3'd0;
                    end else begin
                        res0  = tok((r_kind == LIT_NULL) ? TT_NULL : TT_BOOLEAN,
                                    r_byte, 1'b1, 1'b0);
                        n_pos = pos_inc;
                    end
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase
        end
        if (cnt == 2'd1) begin
            res0.last_of_step = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last_of_step = 1'b1;
        end
    end

    assign o_push = take ? cnt : 2'd0;
    assign o_res0 = res0;
    assign o_res1 = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_mode <= MODE_IDLE;
            r_kind <= LIT_TRUE;
            r_pos  <= 3'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_vld <= 1'b1;
            end else if (take) begin
                r_vld <= 1'b0;
            end
            if (take) begin
                r_mode <= n_mode;
                r_kind <= n_kind;
                r_pos  <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_eoi  <= i_in.end_of_input;
        end
    end

    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_FAILED |=> r_mode == MODE_FAILED)
        else $error("failed mode was left");

    a_two_only_after_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push == 2'd2 |-> o_res0.token_type == TT_NUMBER && o_res0.token_complete
                           && !o_res0.last_of_step && o_res1.last_of_step)
        else $error("two results without a number close");

    a_no_push_without_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push != 2'd0 |-> i_room && r_vld)
        else $error("push without room");

    a_failed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_FAILED |-> o_push == 2'd0)
        else $error("result after failure");

endmodule

`default_nettype wire

@@ rtl/jtl_out_fifo.sv @@
// Small queue taking up to two token results per cycle, issuing one if ready.
`default_nettype none

module jtl_out_fifo
    import jtl_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire [1:0]    i_push,
    input  wire t_result i_res0,
    input  wire t_result i_res1,
    output logic         o_room,
    jtl_out_if.source    o_out
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   wr_nxt;
    logic            pop;
    t_result         head;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_nxt = ptr_inc(r_wr);
    assign pop    = o_out.valid && o_out.ready;
    assign o_room = r_count <= CW'(DEPTH - 2);
    assign head   = r_mem[r_rd];

    assign o_out.valid          = r_count != '0;
    assign o_out.token_type     = head.token_type;
    assign o_out.value_byte     = head.value_byte;
    assign o_out.has_value_byte = head.has_value_byte;
    assign o_out.token_complete = head.token_complete;
    assign o_out.error_flag     = head.error_flag;
    assign o_out.last_of_step   = head.last_of_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push == 2'd1) begin
                r_wr <= wr_nxt;
            end else if (i_push == 2'd2) begin
                r_wr <= ptr_inc(wr_nxt);
            end
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[wr_nxt] <= i_res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count overflow");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push != 2'd0 |-> o_room)
        else $error("push into full queue");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_count == '0)
        else $error("queue not empty after reset");

endmodule

`default_nettype wire

@@ rtl/json_token_lexer.sv @@
// Top level of the streaming JSON token lexer.
//
//  Channel  Dir  Handshake      Payload
//  i_in     in   valid/ready    data_byte[7:0], end_of_input
//  o_out    out  valid/ready    token_type[3:0], value_byte[7:0], has_value_byte,
//                               token_complete, error_flag, last_of_step
//
// One byte request per cycle while the result queue has room: a byte is held in the
// input register and its zero to two results go into the result queue as it is taken.
// Bytes that give two results (a number closed by a byte that gives its own result) take two output slots.
// The input register stalls while the result queue has fewer than two free entries.
// Synchronous active-low reset: lexer between tokens, queue empty, no clearing pass.
`default_nettype none

module json_token_lexer
    import jtl_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    jtl_in_if.sink       i_in,
    jtl_out_if.source    o_out
);

    logic       room;
    logic [1:0] push;
    t_result    res0;
    t_result    res1;

    jtl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    jtl_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
